[rtl/bump_allocator_object_finder_macros.svh]
// Assertion macros for the bump allocator object finder.
// Included by the top level; no other dependencies.
`ifndef BUMP_ALLOCATOR_OBJECT_FINDER_MACROS_SVH
`define BUMP_ALLOCATOR_OBJECT_FINDER_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every rising clock edge outside reset
`define BAFO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bafo assertion failed");
// antecedent implies consequent in the same cycle
`define BAFO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bafo implication failed");
`else
`define BAFO_ASSERT(lbl, clk, rst_n, prop)
`define BAFO_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bafo_pkg.sv]
// Shared types and constants for the bump allocator object finder.
// No dependencies.
package bafo_pkg;

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FIND  = 2'd1;
  localparam logic [1:0] ACT_NEWPG = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_NO_OBJ   = 2'd3;

  localparam int OFF_W      = 21;
  localparam int CFG_W      = 22;
  localparam int SIZE_W     = 17;
  localparam int HDR_BYTES  = 8;
  localparam int WORD_BITS  = 64;
  localparam int WORD_BYTES = 512;
  localparam int BIT_W      = 6;
  localparam int USABLE_RST = 2060264;

  typedef struct packed {
    logic [1:0]       action;
    logic [15:0]      payload_size;
    logic [OFF_W-1:0] interior_offset;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  object_offset;
    logic [SIZE_W-1:0] total_size;
  } res_t;

  // outcome of scanning one bitmap word
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_t;

endpackage

[rtl/bafo_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bafo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bafo_word_scan.sv]
// Masks a bitmap word to bits at or below a limit and finds the highest set bit.
// Depends on bafo_pkg.
module bafo_word_scan (
  input  logic [bafo_pkg::WORD_BITS-1:0] word_i,
  input  logic [bafo_pkg::BIT_W-1:0]     lim_i,
  output bafo_pkg::scan_t                scan_o
);

  logic [bafo_pkg::WORD_BITS-1:0] masked;

  always_comb begin
    for (int k = 0; k < bafo_pkg::WORD_BITS; k++) begin
      masked[k] = word_i[k] && (bafo_pkg::BIT_W'(k) <= lim_i);
    end
  end

  // priority encode, highest wins
  always_comb begin
    scan_o.hit = |masked;
    scan_o.pos = '0;
    for (int k = 0; k < bafo_pkg::WORD_BITS; k++) begin
      if (masked[k]) begin
        scan_o.pos = bafo_pkg::BIT_W'(k);
      end
    end
  end

endmodule

[rtl/bump_allocator_object_finder.sv]
// Top level of the bump allocator object finder: control, used count, bitmap RAM.
// Depends on bafo_pkg, bafo_ram, bafo_word_scan and the macros header.
//
// Usage
//   Commands: drive cmd_i and raise start_i; the beat is taken on a rising edge
//   with start_i high and busy_o low. One result beat per command appears on
//   res_o for a single cycle with valid_o high; the receiver cannot stall it.
//   cfg_we_i writes usable_bytes from cfg_wdata_i; the user must write it only
//   while the block is idle; the block itself does not enforce this.
// Command flow
//   Bad size, page full and unused action: result the cycle after acceptance,
//   next command may start in that same cycle. Allocate: bitmap read then
//   read-modify-write. Find: first read at acceptance, then one bitmap word
//   after another, walking down from the word that holds the offset, until a
//   hit or word 0. New page: clearing pass over the bitmap RAM, one word per
//   cycle, then the result.
// Reset
//   Reset zeroes the used count and loads usable_bytes with its reset value,
//   then runs the same clearing pass (busy_o high) with no result beat.
//   Config writes are still taken during the pass.
// The bitmap word RAM port is the only shared resource; one access per cycle.
`include "bump_allocator_object_finder_macros.svh"

module bump_allocator_object_finder #(
  parameter int PAGE_BYTES       = 2097152,
  parameter int BITMAP_WORDS     = 4096,
  parameter int MAX_OBJECT_BYTES = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  bafo_pkg::cmd_t                cmd_i,
  output logic                          valid_o,
  output bafo_pkg::res_t                res_o,
  input  logic                          cfg_we_i,
  input  logic [bafo_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int WIDX    = $clog2(BITMAP_WORDS);
  localparam int GMAX    = BITMAP_WORDS * bafo_pkg::WORD_BITS - 1;
  localparam int BM_CAP  = BITMAP_WORDS * bafo_pkg::WORD_BYTES;
  localparam int LIM_CAP = (PAGE_BYTES < BM_CAP) ? PAGE_BYTES : BM_CAP;
  localparam int G_W     = bafo_pkg::OFF_W - 3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_FIND  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bafo_pkg::OFF_W-1:0]  used_q, used_d;
  logic [bafo_pkg::CFG_W-1:0]  usable_q;
  logic [WIDX-1:0]             idx_q, idx_d;     // word in use, or clear pointer
  logic [bafo_pkg::BIT_W-1:0]  bit_q, bit_d;     // alloc bit, or find bit limit
  logic [bafo_pkg::SIZE_W-1:0] total_q, total_d;
  logic                        reply_q, reply_d; // clear pass owes a result
  logic                        valid_q, valid_d;
  bafo_pkg::res_t              res_q, res_d;

  // bitmap RAM port
  logic                            ram_we, ram_re;
  logic [WIDX-1:0]                 ram_waddr, ram_raddr;
  logic [bafo_pkg::WORD_BITS-1:0]  ram_wdata, ram_rdata;

  bafo_pkg::scan_t scan;

  bafo_ram #(
    .WIDTH (bafo_pkg::WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bafo_word_scan u_scan (
    .word_i (ram_rdata),
    .lim_i  (bit_q),
    .scan_o (scan)
  );

  // command decode, valid in the accept cycle
  logic                        accept;
  logic [bafo_pkg::SIZE_W-1:0] req_total;
  logic [bafo_pkg::CFG_W-1:0]  limit, req_end;
  logic                        bad_size, page_full;
  logic [G_W-1:0]              gran, gran_c;

  assign accept    = start_i && (state_q == S_IDLE);
  assign req_total = bafo_pkg::SIZE_W'(cmd_i.payload_size)
                   + bafo_pkg::SIZE_W'(bafo_pkg::HDR_BYTES);
  assign bad_size  = (cmd_i.payload_size[2:0] != 3'd0)
                   || (req_total > bafo_pkg::SIZE_W'(MAX_OBJECT_BYTES));
  // limit saturated to the page and to what the bitmap covers
  assign limit     = (usable_q > bafo_pkg::CFG_W'(LIM_CAP)) ?
                     bafo_pkg::CFG_W'(LIM_CAP) : usable_q;
  assign req_end   = bafo_pkg::CFG_W'(used_q) + bafo_pkg::CFG_W'(req_total);
  assign page_full = (req_end >= limit);
  assign gran      = cmd_i.interior_offset[bafo_pkg::OFF_W-1:3];
  assign gran_c    = (gran > G_W'(GMAX)) ? G_W'(GMAX) : gran;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    total_d   = total_q;
    reply_d   = reply_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (cmd_i.action)
            bafo_pkg::ACT_ALLOC: begin
              if (bad_size) begin
                valid_d      = 1'b1;
                res_d.status = bafo_pkg::ST_BAD_SIZE;
              end else if (page_full) begin
                valid_d      = 1'b1;
                res_d.status = bafo_pkg::ST_FULL;
              end else begin
                idx_d     = WIDX'(used_q >> 9);
                bit_d     = used_q[8:3];
                total_d   = req_total;
                ram_re    = 1'b1;
                ram_raddr = WIDX'(used_q >> 9);
                state_d   = S_ALLOC;
              end
            end
            bafo_pkg::ACT_FIND: begin
              idx_d     = WIDX'(gran_c >> 6);
              bit_d     = gran_c[5:0];
              ram_re    = 1'b1;
              ram_raddr = WIDX'(gran_c >> 6);
              state_d   = S_FIND;
            end
            bafo_pkg::ACT_NEWPG: begin
              used_d  = '0;
              idx_d   = '0;
              reply_d = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              valid_d = 1'b1;   // unused action: plain ok
            end
          endcase
        end
      end

      S_ALLOC: begin
        // read data for the start word is here: set the bit and write back
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (bafo_pkg::WORD_BITS'(1) << bit_q);
        used_d    = used_q + bafo_pkg::OFF_W'(total_q);
        valid_d   = 1'b1;
        res_d.status        = bafo_pkg::ST_OK;
        res_d.object_offset = used_q;
        res_d.total_size    = total_q;
        state_d   = S_IDLE;
      end

      S_FIND: begin
        if (scan.hit) begin
          valid_d = 1'b1;
          res_d.status        = bafo_pkg::ST_OK;
          res_d.object_offset = bafo_pkg::OFF_W'({idx_q, scan.pos, 3'b000});
          state_d = S_IDLE;
        end else if (idx_q == '0) begin
          valid_d = 1'b1;
          res_d.status        = bafo_pkg::ST_NO_OBJ;
          res_d.object_offset = '0;
          state_d = S_IDLE;
        end else begin
          // step back one word, whole word in range now
          idx_d     = idx_q - WIDX'(1);
          bit_d     = '1;
          ram_re    = 1'b1;
          ram_raddr = idx_q - WIDX'(1);
        end
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
        if (idx_q == WIDX'(BITMAP_WORDS - 1)) begin
          valid_d = reply_q;
          res_d   = '0;
          reply_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + WIDX'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      used_q   <= '0;
      usable_q <= bafo_pkg::CFG_W'(bafo_pkg::USABLE_RST);
      idx_q    <= '0;
      reply_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      reply_q <= reply_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        usable_q <= cfg_wdata_i;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    bit_q   <= bit_d;
    total_q <= total_d;
    res_q   <= res_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // every result leaves the block back in idle
  `BAFO_ASSERT_IMP(a_valid_idle, clk_i, rst_ni, valid_o, state_q == S_IDLE)
  // the write-back always delivers its result on the next edge
  `BAFO_ASSERT(a_alloc_reply, clk_i, rst_ni, (state_q == S_ALLOC) |=> valid_o)
  // bump pointer never runs past what the bitmap and page cover
  `BAFO_ASSERT(a_used_cap, clk_i, rst_ni,
               bafo_pkg::CFG_W'(used_q) < bafo_pkg::CFG_W'(LIM_CAP))
  // a clear pass only writes, never reads
  `BAFO_ASSERT_IMP(a_clear_wr, clk_i, rst_ni, state_q == S_CLEAR, ram_we && !ram_re)

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for bump_allocator_object_finder: directed table, then random phases.
// Depends on bafo_pkg and the block's RTL; a local heap model predicts every result beat.

module testbench;

  localparam int PAGE_BYTES       = 2097152;
  localparam int BITMAP_WORDS     = 4096;
  localparam int MAX_OBJECT_BYTES = 65536;

  // action 3 has no name in the package; the block answers it with a zero beat
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // longest legal quiet stretch is a full bitmap walk or clear
  localparam int STALL_LIMIT  = 25000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 125;
  localparam int TAIL_CYCLES  = 20;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  bafo_pkg::cmd_t               cmd_i;
  logic                         valid_o;
  bafo_pkg::res_t               res_o;
  logic                         cfg_we_i;
  logic [bafo_pkg::CFG_W-1:0]   cfg_wdata_i;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bump_allocator_object_finder #(
    .PAGE_BYTES      (PAGE_BYTES),
    .BITMAP_WORDS    (BITMAP_WORDS),
    .MAX_OBJECT_BYTES(MAX_OBJECT_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .valid_o    (valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Heap model: start bitmap, bump pointer and the usable_bytes register copy
  // ---------------------------------------------------------------------------
  logic [bafo_pkg::WORD_BITS-1:0] start_map [BITMAP_WORDS];
  int unsigned                    used_bytes;
  logic [bafo_pkg::CFG_W-1:0]     usable_bytes_q;

  bafo_pkg::res_t outcome_q [$];   // predicted result beats, oldest first
  int unsigned    fail_count = 0;

  function automatic void clear_heap();
    foreach (start_map[i]) start_map[i] = '0;
    used_bytes = 0;
  endfunction

  // Applies one command to the heap model and returns the beat it should produce.
  function automatic bafo_pkg::res_t heap_outcome(input bafo_pkg::cmd_t c);
    bafo_pkg::res_t                 r;
    int unsigned                    size;
    int unsigned                    lim;
    int unsigned                    g;
    int unsigned                    wi;
    int                             b;
    logic [bafo_pkg::WORD_BITS-1:0] w;
    r = '0;
    case (c.action)
      bafo_pkg::ACT_ALLOC: begin
        size = 32'(c.payload_size) + bafo_pkg::HDR_BYTES;
        // room limit saturates to the page and to what the bitmap covers
        lim = 32'(usable_bytes_q);
        if (lim > PAGE_BYTES) lim = PAGE_BYTES;
        if (lim > BITMAP_WORDS * bafo_pkg::WORD_BYTES) lim = BITMAP_WORDS * bafo_pkg::WORD_BYTES;
        // size check wins over the room check
        if (c.payload_size[2:0] != 3'd0 || size > MAX_OBJECT_BYTES) begin
          r.status = bafo_pkg::ST_BAD_SIZE;
        end else if (used_bytes + size >= lim) begin
          r.status = bafo_pkg::ST_FULL;
        end else begin
          g = used_bytes >> 3;
          start_map[(g / bafo_pkg::WORD_BITS) % BITMAP_WORDS][g % bafo_pkg::WORD_BITS] = 1'b1;
          r.status        = bafo_pkg::ST_OK;
          r.object_offset = bafo_pkg::OFF_W'(used_bytes);
          r.total_size    = bafo_pkg::SIZE_W'(size);
          used_bytes      = (used_bytes + size) & 32'h1F_FFFF;
        end
      end
      bafo_pkg::ACT_FIND: begin
        g = 32'(c.interior_offset) >> 3;
        // offsets past the bitmap clamp to its last granule
        if (g >= BITMAP_WORDS * bafo_pkg::WORD_BITS) g = BITMAP_WORDS * bafo_pkg::WORD_BITS - 1;
        wi = g / bafo_pkg::WORD_BITS;
        // mask the home word first, then walk back word by word
        w = start_map[wi] & ({bafo_pkg::WORD_BITS{1'b1}}
                             >> (bafo_pkg::WORD_BITS - 1 - (g % bafo_pkg::WORD_BITS)));
        while (w == '0 && wi > 0) begin
          wi--;
          w = start_map[wi];
        end
        if (w == '0) begin
          r.status = bafo_pkg::ST_NO_OBJ;
        end else begin
          b = bafo_pkg::WORD_BITS - 1;
          while (b > 0 && !w[b]) b--;
          r.object_offset = bafo_pkg::OFF_W'(wi * bafo_pkg::WORD_BYTES
                                             + b * bafo_pkg::HDR_BYTES);
        end
      end
      bafo_pkg::ACT_NEWPG: clear_heap();
      default: ;  // unused action: nothing changes, zero beat
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : beat_check
    bafo_pkg::res_t want;
    if (rst_ni && valid_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual status %0d offset %0d size %0d",
                 $time, res_o.status, res_o.object_offset, res_o.total_size);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", 32'(want.status), 32'(res_o.status));
        check_field("object_offset", 32'(want.object_offset), 32'(res_o.object_offset));
        check_field("total_size", 32'(want.total_size), 32'(res_o.total_size));
      end
    end
  end

  // Watchdog: any accepted command or result beat restarts the count.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------
  // Holds start until the beat is taken, then books the predicted or typed result.
  // start stays high on return so back-to-back commands need no extra edge.
  task automatic issue(input bafo_pkg::cmd_t c, input bit typed,
                       input bafo_pkg::res_t typed_res);
    bafo_pkg::res_t predicted;
    cmd_i   <= c;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    predicted = heap_outcome(c);
    outcome_q.push_back(typed ? typed_res : predicted);
  endtask

  // Sender pause until every booked beat has come back and the block is idle.
  task automatic drain_outcomes();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0 || busy_o);
  endtask

  // usable_bytes only changes while the block is idle
  task automatic write_usable(input logic [bafo_pkg::CFG_W-1:0] v);
    drain_outcomes();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    usable_bytes_q = v;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit                         is_cfg;
    logic [bafo_pkg::CFG_W-1:0] cfg_val;
    bafo_pkg::cmd_t             cmd;
    bit                         typed;
    bafo_pkg::res_t             want;
  } stim_row_t;

  stim_row_t directed_q [$];

  function automatic void add_cmd(input logic [1:0] act, input logic [15:0] pay,
                                  input logic [bafo_pkg::OFF_W-1:0] off);
    stim_row_t row;
    row = '0;
    row.cmd.action          = act;
    row.cmd.payload_size    = pay;
    row.cmd.interior_offset = off;
    directed_q.push_back(row);
  endfunction

  function automatic void add_typed(input logic [1:0] act, input logic [15:0] pay,
                                    input logic [bafo_pkg::OFF_W-1:0] off,
                                    input logic [1:0] st,
                                    input logic [bafo_pkg::OFF_W-1:0] obj,
                                    input logic [bafo_pkg::SIZE_W-1:0] tot);
    stim_row_t row;
    row = '0;
    row.cmd.action          = act;
    row.cmd.payload_size    = pay;
    row.cmd.interior_offset = off;
    row.typed               = 1'b1;
    row.want.status         = st;
    row.want.object_offset  = obj;
    row.want.total_size     = tot;
    directed_q.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [bafo_pkg::CFG_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    directed_q.push_back(row);
  endfunction

  function automatic void build_directed();
    // empty page straight after reset: nothing to find, bottom and top offsets
    add_typed(bafo_pkg::ACT_FIND, 16'h0, 21'h0, bafo_pkg::ST_NO_OBJ, 21'd0, 17'd0);
    add_typed(bafo_pkg::ACT_FIND, 16'h0, 21'h1F_FFFF, bafo_pkg::ST_NO_OBJ, 21'd0, 17'd0);
    // misaligned payloads and the largest odd one are bad sizes
    add_typed(bafo_pkg::ACT_ALLOC, 16'h0001, 21'h0, bafo_pkg::ST_BAD_SIZE, 21'd0, 17'd0);
    add_typed(bafo_pkg::ACT_ALLOC, 16'hFFFF, 21'h0, bafo_pkg::ST_BAD_SIZE, 21'd0, 17'd0);
    // largest legal object lands at offset 0, header included
    add_typed(bafo_pkg::ACT_ALLOC, 16'hFFF8, 21'h0, bafo_pkg::ST_OK, 21'd0,
              bafo_pkg::SIZE_W'(MAX_OBJECT_BYTES));
    add_cmd(bafo_pkg::ACT_ALLOC, 16'h0, 21'h0);
    add_typed(bafo_pkg::ACT_ALLOC, 16'hFFFA, 21'h0, bafo_pkg::ST_BAD_SIZE, 21'd0, 17'd0);
    add_cmd(bafo_pkg::ACT_ALLOC, 16'h0008, 21'h0);
    // finds on and around object starts, and a long walk from the page top
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'd0);
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'd65535);
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'd65536);
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'd65551);
    add_cmd(bafo_pkg::ACT_FIND, 16'hFFFF, 21'h1F_FFFF);
    // unused action and new page both answer with a zero beat
    add_typed(ACT_UNUSED, 16'hFFFF, 21'h1F_FFFF, bafo_pkg::ST_OK, 21'd0, 17'd0);
    add_typed(bafo_pkg::ACT_NEWPG, 16'hFFFF, 21'h1F_FFFF, bafo_pkg::ST_OK, 21'd0, 17'd0);
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'd65551);
    add_cmd(bafo_pkg::ACT_ALLOC, 16'd16, 21'h0);
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'd7);
    // register value 8: every legal allocation is full
    add_cfg(22'd8);
    add_typed(bafo_pkg::ACT_ALLOC, 16'h0, 21'h0, bafo_pkg::ST_FULL, 21'd0, 17'd0);
    // used = 24 here: 24 + 8 hitting the limit exactly is full, one above is not
    add_cfg(22'd32);
    add_cmd(bafo_pkg::ACT_ALLOC, 16'h0, 21'h0);
    add_cfg(22'd33);
    add_cmd(bafo_pkg::ACT_ALLOC, 16'h0, 21'h0);
    // all-ones register saturates to the page size
    add_cfg({bafo_pkg::CFG_W{1'b1}});
    add_cmd(bafo_pkg::ACT_ALLOC, 16'hFFF8, 21'h0);
    add_cmd(bafo_pkg::ACT_FIND, 16'h0, 21'h10_0000);
    add_cfg(bafo_pkg::CFG_W'(bafo_pkg::USABLE_RST));
  endfunction

  // ---------------------------------------------------------------------------
  // Random commands: mostly well-formed allocations and nearby finds
  // ---------------------------------------------------------------------------
  function automatic bafo_pkg::cmd_t random_cmd();
    bafo_pkg::cmd_t c;
    int unsigned    pick;
    int unsigned    reach;
    c.action          = bafo_pkg::ACT_ALLOC;
    c.payload_size    = 16'($urandom);
    c.interior_offset = bafo_pkg::OFF_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      pick = $urandom_range(99);
      if (pick < 55) c.payload_size = 16'(8 * $urandom_range(0, 31));
      else if (pick < 85) c.payload_size = 16'(8 * $urandom_range(0, 8191));
      else if (pick < 92) c.payload_size = 16'hFFF8;
      // else keep the raw payload: mostly misaligned
    end else if (pick < 92) begin
      c.action = bafo_pkg::ACT_FIND;
      // far finds walk the whole bitmap, so keep most near the bump pointer
      if ($urandom_range(9) != 0) begin
        reach = used_bytes + 32'd600;
        if (reach > 32'h1F_FFFF) reach = 32'h1F_FFFF;
        c.interior_offset = bafo_pkg::OFF_W'($urandom_range(0, reach));
      end
    end else if (pick < 96) begin
      c.action = bafo_pkg::ACT_NEWPG;
    end else begin
      c.action = ACT_UNUSED;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned                phase;
    int unsigned                k;
    logic [bafo_pkg::CFG_W-1:0] setting;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    clear_heap();
    usable_bytes_q = bafo_pkg::CFG_W'(bafo_pkg::USABLE_RST);
    build_directed();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // block runs its clearing pass now; issue waits on busy
    foreach (directed_q[i]) begin
      if (directed_q[i].is_cfg) write_usable(directed_q[i].cfg_val);
      else issue(directed_q[i].cmd, directed_q[i].typed, directed_q[i].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: setting = bafo_pkg::CFG_W'(PAGE_BYTES);
        1: setting = bafo_pkg::CFG_W'($urandom_range(64, 4096));
        2: setting = {bafo_pkg::CFG_W{1'b1}};
        3: setting = 22'd8;
        4: setting = bafo_pkg::CFG_W'($urandom_range(8, 22'h3F_FFFF));
        5: setting = bafo_pkg::CFG_W'(bafo_pkg::USABLE_RST);
        6: setting = bafo_pkg::CFG_W'($urandom_range(4096, 262144));
        default: setting = bafo_pkg::CFG_W'(PAGE_BYTES);
      endcase
      write_usable(setting);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        issue(random_cmd(), 1'b0, '0);
        // the last phase runs flat out
        if (phase < PHASES - 1) begin
          // mid-phase: sender waits out every outstanding beat
          if (k == PHASE_ITEMS / 2) begin
            drain_outcomes();
          end else if ($urandom_range(4) == 0) begin
            // sender gap
            start_i <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk_i);
          end
        end
      end
    end

    drain_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[bump_allocator_object_finder.f]
+incdir+rtl
rtl/bafo_pkg.sv
rtl/bafo_ram.sv
rtl/bafo_word_scan.sv
rtl/bump_allocator_object_finder.sv
sim/testbench.sv
